// File: hw/rtl/bcs_pkg.sv
// Shared types, register indexes and reset values for the charge sequencer.
// No dependencies; used by bcs_step and battery_charge_sequencer.
`timescale 1ns / 1ps

package bcs_pkg;

    // Sequence states, one-hot
    typedef enum logic [7:0] {
        PH_INIT         = 8'b0000_0001,
        PH_WAIT_INIT    = 8'b0000_0010,
        PH_WAIT_ENABLE  = 8'b0000_0100,
        PH_WAIT_CHARGER = 8'b0000_1000,
        PH_SETTLE       = 8'b0001_0000,
        PH_CHARGING     = 8'b0010_0000,
        PH_FINISHED     = 8'b0100_0000,
        PH_ERROR        = 8'b1000_0000
    } t_phase;

    // Reported state codes
    localparam logic [2:0] CODE_INIT         = 3'd0;
    localparam logic [2:0] CODE_WAIT_INIT    = 3'd1;
    localparam logic [2:0] CODE_WAIT_ENABLE  = 3'd2;
    localparam logic [2:0] CODE_WAIT_CHARGER = 3'd3;
    localparam logic [2:0] CODE_SETTLE       = 3'd4;
    localparam logic [2:0] CODE_CHARGING     = 3'd5;
    localparam logic [2:0] CODE_FINISHED     = 3'd6;
    localparam logic [2:0] CODE_ERROR        = 3'd7;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_DELAY      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE          = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGER_PRESENT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_LIMIT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL            = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CURRENT     = 3'd5;

    // Reset values
    localparam logic [31:0] RST_INIT_DELAY_TICKS   = 32'd10000;
    localparam logic [31:0] RST_SETTLE_TICKS       = 32'd1000;
    localparam logic [15:0] RST_CHARGER_PRESENT_MV = 16'd20000;
    localparam logic [15:0] RST_START_LIMIT_MV     = 16'd40000;
    localparam logic [15:0] RST_FULL_MV            = 16'd41000;
    localparam logic [14:0] RST_MIN_CURRENT_MA     = 15'd500;

    // Stream widths (fields packed from bit 0, padded to bytes)
    localparam int unsigned IN_BITS  = 98;
    localparam int unsigned IN_W     = 104;
    localparam int unsigned OUT_BITS = 22;
    localparam int unsigned OUT_W    = 24;

    typedef struct packed {
        logic [31:0] init_delay_ticks;
        logic [31:0] settle_ticks;
        logic [15:0] charger_present_mv;
        logic [15:0] start_limit_mv;
        logic [15:0] full_mv;
        logic [14:0] min_current_ma;
    } t_cfg;

    typedef struct packed {
        logic               bms_permit;
        logic signed [15:0] filtered_ma;
        logic signed [15:0] charge_ma;
        logic [15:0]        bus_mv;
        logic [15:0]        charger_mv;
        logic               charge_enable;
        logic [31:0]        now_ticks;
    } t_item;

    typedef struct packed {
        logic signed [15:0] offset_ma;
        logic               offset_valid;
        logic               motor_lock_request;
        logic               relay_on;
        logic [2:0]         state_code;
    } t_result;

    function automatic logic [2:0] phase_code(input t_phase ph);
        logic [2:0] c;
        case (ph)
            PH_INIT:         c = CODE_INIT;
            PH_WAIT_INIT:    c = CODE_WAIT_INIT;
            PH_WAIT_ENABLE:  c = CODE_WAIT_ENABLE;
            PH_WAIT_CHARGER: c = CODE_WAIT_CHARGER;
            PH_SETTLE:       c = CODE_SETTLE;
            PH_CHARGING:     c = CODE_CHARGING;
            PH_FINISHED:     c = CODE_FINISHED;
            default:         c = CODE_ERROR;
        endcase
        return c;
    endfunction

endpackage

// File: hw/rtl/bcs_step.sv
// One evaluation step of the charge sequence: next state, timestamp, relay and result.
// Depends on bcs_pkg.
`timescale 1ns / 1ps

module bcs_step (
    input  bcs_pkg::t_item   i_item,
    input  bcs_pkg::t_cfg    i_cfg,
    input  bcs_pkg::t_phase  i_phase,
    input  logic [31:0]      i_start_time,
    input  logic             i_relay,
    output bcs_pkg::t_phase  o_phase,
    output logic [31:0]      o_start_time,
    output logic             o_relay,
    output bcs_pkg::t_result o_result
);
    import bcs_pkg::*;

    t_phase      w_phase;
    logic [31:0] w_elapsed;
    logic        w_lock;
    logic        w_offv;

    // wrapping difference
    assign w_elapsed = i_item.now_ticks - i_start_time;

    always_comb begin
        w_phase      = i_item.charge_enable ? i_phase : PH_WAIT_ENABLE;
        o_phase      = w_phase;
        o_start_time = i_start_time;
        o_relay      = i_relay;
        w_lock       = 1'b0;
        w_offv       = 1'b0;
        case (w_phase)
            PH_INIT: begin
                o_relay      = 1'b0;
                o_start_time = i_item.now_ticks;
                o_phase      = PH_WAIT_INIT;
            end
            PH_WAIT_INIT: begin
                if (w_elapsed > i_cfg.init_delay_ticks) begin
                    o_phase = PH_WAIT_CHARGER;
                end
            end
            PH_WAIT_ENABLE: begin
                if (i_item.charge_enable) begin
                    o_phase = PH_INIT;
                end
            end
            PH_WAIT_CHARGER: begin
                w_offv = 1'b1;
                w_lock = (i_item.charger_mv > i_cfg.charger_present_mv);
                if (i_item.charger_mv > i_item.bus_mv &&
                    i_item.bus_mv < i_cfg.start_limit_mv) begin
                    o_relay      = 1'b1;
                    o_start_time = i_item.now_ticks;
                    o_phase      = PH_SETTLE;
                end
            end
            PH_SETTLE: begin
                // full voltage wins over the settle timeout
                if (i_item.bus_mv >= i_cfg.full_mv) begin
                    o_relay = 1'b0;
                    o_phase = PH_FINISHED;
                end else if (w_elapsed > i_cfg.settle_ticks) begin
                    o_phase = PH_CHARGING;
                end
            end
            PH_CHARGING: begin
                if (i_item.bus_mv >= i_cfg.full_mv ||
                    i_item.charge_ma < $signed({1'b0, i_cfg.min_current_ma}) ||
                    !i_item.bms_permit) begin
                    o_relay = 1'b0;
                    o_phase = PH_FINISHED;
                end
            end
            default: begin
                // finished and error
                if (i_item.charger_mv < i_cfg.charger_present_mv) begin
                    o_phase = PH_WAIT_CHARGER;
                end
            end
        endcase
    end

    always_comb begin
        o_result.state_code         = phase_code(o_phase);
        o_result.relay_on           = o_relay;
        o_result.motor_lock_request = w_lock;
        o_result.offset_valid       = w_offv;
        o_result.offset_ma          = w_offv ? i_item.filtered_ma : 16'sd0;
    end

endmodule

// File: hw/rtl/battery_charge_sequencer.sv
// Top level of the battery charge sequencer: stream ports, config registers, pipeline.
// Depends on bcs_pkg and bcs_step.
`timescale 1ns / 1ps

// Each input word is one periodic evaluation; each produces exactly one result
// word, in order. A word is captured into an input register, evaluated against
// the sequence state in one pass of compare logic (one 32-bit wrapping subtract
// and compare sets the path), and the result lands in an output register, so
// the block takes one word per clock while results are accepted; a result word
// turns valid when its word moves from the input register to the output
// register. While a result word waits unaccepted, the input register takes one
// more word and then holds ready low until the result leaves; ready on the input
// side follows the result-side ready in the same cycle. Configuration writes
// take effect on the next clock; write them only while no evaluation is in flight.
// Register indexes 0..5 are init delay, settle time, charger-present voltage,
// start limit, full voltage and minimum current; other indexes are ignored.
module battery_charge_sequencer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration
    input  logic                         i_cfg_we,
    input  logic [bcs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]                  i_cfg_wdata,
    // input stream
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // now_ticks[31:0], charge_enable[32], charger_mv[48:33], bus_mv[64:49],
    // charge_ma[80:65], filtered_ma[96:81], bms_permit[97], zero pad
    input  logic [bcs_pkg::IN_W-1:0]     s_axis_tdata,
    // result stream
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // state_code[2:0], relay_on[3], motor_lock_request[4], offset_valid[5],
    // offset_ma[21:6], zero pad
    output logic [bcs_pkg::OUT_W-1:0]    m_axis_tdata
);
    import bcs_pkg::*;

    t_cfg        r_cfg;
    t_phase      r_phase;
    t_phase      n_phase;
    logic [31:0] r_start_time;
    logic [31:0] n_start_time;
    logic        r_relay;
    logic        n_relay;

    logic        r_in_valid;
    t_item       r_in;
    logic        r_out_valid;
    t_result     r_out;
    t_result     n_out;

    logic        w_advance;

    // move the held word to the result register when that slot is free
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    // ---- configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.init_delay_ticks   <= RST_INIT_DELAY_TICKS;
            r_cfg.settle_ticks       <= RST_SETTLE_TICKS;
            r_cfg.charger_present_mv <= RST_CHARGER_PRESENT_MV;
            r_cfg.start_limit_mv     <= RST_START_LIMIT_MV;
            r_cfg.full_mv            <= RST_FULL_MV;
            r_cfg.min_current_ma     <= RST_MIN_CURRENT_MA;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_INIT_DELAY:      r_cfg.init_delay_ticks   <= i_cfg_wdata;
                CFG_SETTLE:          r_cfg.settle_ticks       <= i_cfg_wdata;
                CFG_CHARGER_PRESENT: r_cfg.charger_present_mv <= i_cfg_wdata[15:0];
                CFG_START_LIMIT:     r_cfg.start_limit_mv     <= i_cfg_wdata[15:0];
                CFG_FULL:            r_cfg.full_mv            <= i_cfg_wdata[15:0];
                CFG_MIN_CURRENT:     r_cfg.min_current_ma     <= i_cfg_wdata[14:0];
                default: ;           // drop writes to unused indexes
            endcase
        end
    end

    // ---- input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in <= t_item'(s_axis_tdata[IN_BITS-1:0]);
        end
    end

    // ---- evaluation
    bcs_step u_step (
        .i_item       (r_in),
        .i_cfg        (r_cfg),
        .i_phase      (r_phase),
        .i_start_time (r_start_time),
        .i_relay      (r_relay),
        .o_phase      (n_phase),
        .o_start_time (n_start_time),
        .o_relay      (n_relay),
        .o_result     (n_out)
    );

    // ---- sequence state, advanced once per evaluated word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_INIT;
            r_start_time <= '0;
            r_relay      <= 1'b0;
        end else if (w_advance) begin
            r_phase      <= n_phase;
            r_start_time <= n_start_time;
            r_relay      <= n_relay;
        end
    end

    // ---- result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_W - OUT_BITS){1'b0}}, r_out};

    // ---- checks
    a_offset_only_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.offset_valid) |->
            (r_out.state_code == CODE_WAIT_CHARGER || r_out.state_code == CODE_SETTLE))
        else $error("offset capture outside wait-charger step");

    a_relay_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.relay_on) |->
            (r_out.state_code == CODE_SETTLE || r_out.state_code == CODE_CHARGING ||
             r_out.state_code == CODE_WAIT_ENABLE || r_out.state_code == CODE_INIT))
        else $error("relay on in a state that cannot drive it");

    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("evaluated word did not reach the result register");

    a_state_tracks_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> (r_out.state_code == phase_code(r_phase) && r_out.relay_on == r_relay))
        else $error("result disagrees with sequence state");

endmodule
